[rtl/dpt_pkg.sv]
package dpt_pkg;

	localparam int PAD_COUNT_DEF        = 16;
	localparam int SAMPLE_BITS_DEF      = 12;
	localparam int CURVE_INDEX_BITS_DEF = 10;

	localparam int PAD_NUM_W = 4;
	localparam int LEVEL_W   = 12;
	localparam int HIT_W     = 8;
	localparam int WINDOW_W  = 20;
	localparam int CHAN_W    = 4;
	localparam int TIME_W    = 32;
	localparam int NOTE_W    = 7;
	localparam int VEL_W     = 7;
	localparam int VEL_MAX   = 127;
	localparam int HIT_MAX   = 255;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int OUT_W      = 24;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL   = 3'd5;

	localparam logic [LEVEL_W-1:0]  RST_THRESHOLD = 12'd200;
	localparam logic [LEVEL_W-1:0]  RST_FULL      = 12'd3500;
	localparam logic [LEVEL_W-1:0]  RST_HYST      = 12'd50;
	localparam logic [HIT_W-1:0]    RST_DEBOUNCE  = 8'd3;
	localparam logic [WINDOW_W-1:0] RST_WINDOW    = 20'd2000;
	localparam logic [CHAN_W-1:0]   RST_CHANNEL   = 4'd9;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE = 2'd1;
	localparam logic [1:0] PH_WINDOW   = 2'd2;
	localparam logic [1:0] PH_HELD     = 2'd3;

	localparam logic KIND_ON  = 1'b0;
	localparam logic KIND_OFF = 1'b1;

	localparam int FIX_FRAC = 48;
	localparam longint unsigned FIX_ONE = 64'd1 << FIX_FRAC;

	typedef struct packed {
		logic [LEVEL_W-1:0]  thr;
		logic [LEVEL_W-1:0]  full;
		logic [LEVEL_W-1:0]  hyst;
		logic [HIT_W-1:0]    need;
		logic [WINDOW_W-1:0] window;
		logic [CHAN_W-1:0]   chan;
	} cfg_t;

	typedef struct packed {
		logic                 kind;
		logic [PAD_NUM_W-1:0] pad;
		logic [NOTE_W-1:0]    note;
		logic [VEL_W-1:0]     vel;
		logic [CHAN_W-1:0]    chan;
	} event_t;

	function automatic logic [NOTE_W-1:0] note_of(input logic [PAD_NUM_W-1:0] pad);
		logic [NOTE_W-1:0] n;
		case (pad)
			4'd0:    n = 7'd36;
			4'd1:    n = 7'd38;
			4'd2:    n = 7'd40;
			4'd3:    n = 7'd42;
			4'd4:    n = 7'd44;
			4'd5:    n = 7'd46;
			4'd6:    n = 7'd49;
			4'd7:    n = 7'd51;
			4'd8:    n = 7'd41;
			4'd9:    n = 7'd43;
			4'd10:   n = 7'd45;
			4'd11:   n = 7'd47;
			4'd12:   n = 7'd48;
			4'd13:   n = 7'd50;
			4'd14:   n = 7'd52;
			default: n = 7'd55;
		endcase
		return n;
	endfunction

	// floor quotient by shift and subtract, elaboration only
	function automatic longint unsigned const_quot(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// e^(v/127) in q48, truncated taylor series, elaboration only
	function automatic longint unsigned exp_fix(input int unsigned v);
		longint unsigned sum;
		longint unsigned term;
		longint unsigned k;
		sum  = 64'd0;
		term = FIX_ONE;
		k    = 64'd1;
		while (term != 64'd0 && k < 64'd64) begin
			sum  = sum + term;
			term = const_quot(term * longint'(v), 64'd127 * k);
			k    = k + 64'd1;
		end
		return sum;
	endfunction

	// smallest curve index n that reaches velocity v
	function automatic int unsigned curve_step(input int unsigned cib, input int unsigned v);
		longint unsigned em1;
		longint unsigned rhs;
		em1 = exp_fix(127) - FIX_ONE;
		rhs = (exp_fix(v) - FIX_ONE) << cib;
		return int'(const_quot(rhs + em1 - 64'd1, em1));
	endfunction

endpackage

[rtl/dpt_alu.sv]
module dpt_alu #(
	parameter int W = dpt_pkg::TIME_W
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         ge
);

	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = !borrow;

endmodule

[rtl/dpt_pad_mem.sv]
module dpt_pad_mem #(
	parameter int PAD_COUNT   = dpt_pkg::PAD_COUNT_DEF,
	parameter int SAMPLE_BITS = dpt_pkg::SAMPLE_BITS_DEF,
	localparam int PAD_W      = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [PAD_W-1:0]            rd_addr,
	output logic [1:0]                  rd_phase,
	output logic [dpt_pkg::HIT_W-1:0]   rd_hit,
	output logic [SAMPLE_BITS-1:0]      rd_peak,
	output logic [dpt_pkg::TIME_W-1:0]  rd_start,
	input  logic                        wr_en,
	input  logic [PAD_W-1:0]            wr_addr,
	input  logic [1:0]                  wr_phase,
	input  logic [dpt_pkg::HIT_W-1:0]   wr_hit,
	input  logic [SAMPLE_BITS-1:0]      wr_peak,
	input  logic [dpt_pkg::TIME_W-1:0]  wr_start
);

	logic [1:0]                 phase_mem [PAD_COUNT];
	logic [dpt_pkg::HIT_W-1:0]  hit_mem   [PAD_COUNT];
	logic [SAMPLE_BITS-1:0]     peak_mem  [PAD_COUNT];
	logic [dpt_pkg::TIME_W-1:0] start_mem [PAD_COUNT];
	logic [PAD_COUNT-1:0]       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			phase_mem[wr_addr] <= wr_phase;
			hit_mem[wr_addr]   <= wr_hit;
			peak_mem[wr_addr]  <= wr_peak;
			start_mem[wr_addr] <= wr_start;
		end
	end

	// entries never written read as idle with no hits
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_phase <= valid_q[rd_addr] ? phase_mem[rd_addr] : dpt_pkg::PH_IDLE;
			rd_hit   <= valid_q[rd_addr] ? hit_mem[rd_addr] : '0;
			rd_peak  <= peak_mem[rd_addr];
			rd_start <= start_mem[rd_addr];
		end
	end

endmodule

[rtl/dpt_ctrl.sv]
module dpt_ctrl #(
	parameter int PAD_COUNT        = dpt_pkg::PAD_COUNT_DEF,
	parameter int SAMPLE_BITS      = dpt_pkg::SAMPLE_BITS_DEF,
	parameter int CURVE_INDEX_BITS = dpt_pkg::CURVE_INDEX_BITS_DEF,
	localparam int PAD_W           = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dpt_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dpt_pkg::PAD_NUM_W-1:0]     in_pad,
	input  logic [SAMPLE_BITS-1:0]            in_sample,
	input  logic [dpt_pkg::TIME_W-1:0]        in_time,
	output logic                              ev_valid,
	input  logic                              ev_ready,
	output dpt_pkg::event_t                   ev,
	output logic                              rd_en,
	output logic [PAD_W-1:0]                  rd_addr,
	input  logic [1:0]                        rd_phase,
	input  logic [dpt_pkg::HIT_W-1:0]         rd_hit,
	input  logic [SAMPLE_BITS-1:0]            rd_peak,
	input  logic [dpt_pkg::TIME_W-1:0]        rd_start,
	output logic                              wr_en,
	output logic [PAD_W-1:0]                  wr_addr,
	output logic [1:0]                        wr_phase,
	output logic [dpt_pkg::HIT_W-1:0]         wr_hit,
	output logic [SAMPLE_BITS-1:0]            wr_peak,
	output logic [dpt_pkg::TIME_W-1:0]        wr_start,
	output logic [dpt_pkg::TIME_W-1:0]        alu_a,
	output logic [dpt_pkg::TIME_W-1:0]        alu_b,
	input  logic [dpt_pkg::TIME_W-1:0]        alu_diff,
	input  logic                              alu_ge
);

	localparam int CIB   = CURVE_INDEX_BITS;
	localparam int LVW   = (SAMPLE_BITS > dpt_pkg::LEVEL_W) ? SAMPLE_BITS : dpt_pkg::LEVEL_W;
	localparam int CNT_W = $clog2(CIB);
	localparam int TW    = dpt_pkg::TIME_W;
	localparam int LW    = dpt_pkg::LEVEL_W;
	localparam int HW    = dpt_pkg::HIT_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EVAL = 4'd1;
	localparam logic [3:0] S_ELAP = 4'd2;
	localparam logic [3:0] S_WCMP = 4'd3;
	localparam logic [3:0] S_VSET = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_SRCH = 4'd6;
	localparam logic [3:0] S_WB   = 4'd7;

	logic [3:0]                       st_q;
	logic                             wr_q;
	logic                             emit_q;
	logic                             kind_q;
	logic [PAD_W-1:0]                 pad_q;
	logic [dpt_pkg::PAD_NUM_W-1:0]    pad_num_q;
	logic [SAMPLE_BITS-1:0]           smp_q;
	logic [TW-1:0]                    now_q;
	logic [1:0]                       phase_q;
	logic [HW-1:0]                    hit_q;
	logic [SAMPLE_BITS-1:0]           peak_q;
	logic [TW-1:0]                    start_q;
	logic [TW-1:0]                    elap_q;
	logic [LW-1:0]                    rem_q;
	logic [LW-1:0]                    den_q;
	logic [CIB-1:0]                   quo_q;
	logic [dpt_pkg::VEL_W-1:0]        lo_q;
	logic [dpt_pkg::VEL_W-1:0]        vel_q;
	logic [CNT_W-1:0]                 cnt_q;

	logic [CIB:0]                     step_tab [dpt_pkg::VEL_MAX+1];
	logic                             pad_ok;
	logic                             accept;
	logic                             leave;
	logic [LVW-1:0]                   smp_ext;
	logic [LVW-1:0]                   thr_ext;
	logic [LVW-1:0]                   peak_ext;
	logic                             above;
	logic [HW-1:0]                    hit_inc;
	logic [LW-1:0]                    rel;
	logic                             below_rel;
	logic [dpt_pkg::VEL_W-1:0]        cand;
	logic [dpt_pkg::VEL_W-1:0]        lo_nxt;

	for (genvar g = 0; g <= dpt_pkg::VEL_MAX; g++) begin : g_step
		localparam int unsigned STEP = dpt_pkg::curve_step(CIB, g);
		assign step_tab[g] = (CIB+1)'(STEP);
	end

	assign pad_ok   = (PAD_COUNT > 15) || (in_pad < dpt_pkg::PAD_NUM_W'(PAD_COUNT));
	assign in_ready = (st_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign rd_en    = accept;
	assign rd_addr  = PAD_W'(in_pad);

	assign smp_ext   = LVW'(smp_q);
	assign thr_ext   = LVW'(cfg.thr);
	assign peak_ext  = LVW'(peak_q);
	assign above     = smp_ext > thr_ext;
	assign hit_inc   = (rd_hit == HW'(dpt_pkg::HIT_MAX)) ? rd_hit : rd_hit + 1'b1;
	assign rel       = (cfg.thr > cfg.hyst) ? cfg.thr - cfg.hyst : '0;
	assign below_rel = smp_ext < LVW'(rel);

	assign cand   = lo_q | (dpt_pkg::VEL_W'(1) << cnt_q[2:0]);
	assign lo_nxt = alu_ge ? cand : lo_q;

	always_comb begin
		alu_a = now_q;
		alu_b = start_q;
		case (st_q)
			S_WCMP: begin
				alu_a = elap_q;
				alu_b = TW'(cfg.window);
			end
			S_DIV: begin
				alu_a = TW'({rem_q, 1'b0});
				alu_b = TW'(den_q);
			end
			S_SRCH: begin
				alu_a = TW'(quo_q);
				alu_b = TW'(step_tab[cand]);
			end
			default: begin
				alu_a = now_q;
				alu_b = start_q;
			end
		endcase
	end

	assign leave    = !emit_q || ev_ready;
	assign ev_valid = (st_q == S_WB) && emit_q;
	assign ev.kind  = kind_q;
	assign ev.pad   = pad_num_q;
	assign ev.note  = dpt_pkg::note_of(pad_num_q);
	assign ev.vel   = vel_q;
	assign ev.chan  = cfg.chan;

	assign wr_en    = (st_q == S_WB) && wr_q && leave;
	assign wr_addr  = pad_q;
	assign wr_phase = phase_q;
	assign wr_hit   = hit_q;
	assign wr_peak  = peak_q;
	assign wr_start = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			wr_q   <= 1'b0;
			emit_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						pad_q     <= PAD_W'(in_pad);
						pad_num_q <= in_pad;
						smp_q     <= in_sample;
						now_q     <= in_time;
						wr_q      <= 1'b0;
						emit_q    <= 1'b0;
						if (pad_ok) begin
							st_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					phase_q <= rd_phase;
					hit_q   <= rd_hit;
					peak_q  <= rd_peak;
					start_q <= rd_start;
					st_q    <= S_WB;
					case (rd_phase)
						dpt_pkg::PH_IDLE: begin
							if (above) begin
								wr_q    <= 1'b1;
								phase_q <= dpt_pkg::PH_DEBOUNCE;
								hit_q   <= HW'(1);
							end
						end
						dpt_pkg::PH_DEBOUNCE: begin
							wr_q <= 1'b1;
							if (above) begin
								hit_q <= hit_inc;
								if (hit_inc >= cfg.need) begin
									phase_q <= dpt_pkg::PH_WINDOW;
									peak_q  <= smp_q;
									start_q <= now_q;
								end
							end else begin
								phase_q <= dpt_pkg::PH_IDLE;
								hit_q   <= '0;
							end
						end
						dpt_pkg::PH_WINDOW: begin
							wr_q <= 1'b1;
							if (smp_q > rd_peak) begin
								peak_q <= smp_q;
							end
							st_q <= S_ELAP;
						end
						default: begin
							if (below_rel) begin
								wr_q    <= 1'b1;
								emit_q  <= 1'b1;
								kind_q  <= dpt_pkg::KIND_OFF;
								vel_q   <= '0;
								phase_q <= dpt_pkg::PH_IDLE;
								hit_q   <= '0;
								peak_q  <= '0;
							end
						end
					endcase
				end
				S_ELAP: begin
					elap_q <= alu_diff;
					st_q   <= S_WCMP;
				end
				S_WCMP: begin
					if (alu_ge) begin
						phase_q <= dpt_pkg::PH_HELD;
						emit_q  <= 1'b1;
						kind_q  <= dpt_pkg::KIND_ON;
						st_q    <= S_VSET;
					end else begin
						st_q <= S_WB;
					end
				end
				S_VSET: begin
					rem_q <= LW'(peak_ext - thr_ext);
					den_q <= cfg.full - cfg.thr;
					quo_q <= '0;
					cnt_q <= CNT_W'(CIB - 1);
					if (peak_ext <= thr_ext) begin
						vel_q <= dpt_pkg::VEL_W'(1);
						st_q  <= S_WB;
					end else if (peak_ext >= LVW'(cfg.full)) begin
						vel_q <= dpt_pkg::VEL_W'(dpt_pkg::VEL_MAX);
						st_q  <= S_WB;
					end else begin
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= alu_ge ? LW'(alu_diff) : LW'({rem_q, 1'b0});
					quo_q <= {quo_q[CIB-2:0], alu_ge};
					if (cnt_q == '0) begin
						lo_q  <= '0;
						cnt_q <= CNT_W'(dpt_pkg::VEL_W - 1);
						st_q  <= S_SRCH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SRCH: begin
					lo_q <= lo_nxt;
					if (cnt_q == '0) begin
						vel_q <= (lo_nxt == '0) ? dpt_pkg::VEL_W'(1) : lo_nxt;
						st_q  <= S_WB;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_WB: begin
					if (leave) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_vel_kind: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> ((ev.kind == dpt_pkg::KIND_OFF) == (ev.vel == '0)))
		else $error("note velocity does not match event kind");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pad_ok) |=> (st_q == S_EVAL))
		else $error("accepted word not evaluated");

	a_on_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && ev.kind == dpt_pkg::KIND_ON) |-> (wr_q && phase_q == dpt_pkg::PH_HELD))
		else $error("note-on without pad entering held");
`endif

endmodule

[rtl/drum_pad_trigger_velocity.sv]
// Piezo drum pad trigger. Each input word is one ADC sample of one pad with a microsecond
// timestamp; every pad runs its own idle, debounce, peak window and held sequence and the
// block sends a note-on with a logarithmic velocity at the end of the peak window and a
// note-off when the sample drops below threshold minus hysteresis. Words for pads at or
// above PAD_COUNT are dropped. The block takes no new word until it has finished the last
// one. One 32-bit subtractor is shared by the elapsed-time test, the restoring divide (one
// quotient bit a cycle) and the 7-step binary search of the velocity curve that a
// note-on needs. A result waits in an output register; the block only stalls when a
// second result is ready before the first has been taken.
module drum_pad_trigger_velocity #(
	parameter int PAD_COUNT        = dpt_pkg::PAD_COUNT_DEF,
	parameter int SAMPLE_BITS      = dpt_pkg::SAMPLE_BITS_DEF,
	parameter int CURVE_INDEX_BITS = dpt_pkg::CURVE_INDEX_BITS_DEF,
	localparam int IN_W = ((dpt_pkg::PAD_NUM_W + SAMPLE_BITS + dpt_pkg::TIME_W + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [dpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dpt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_W-1:0]                  s_tdata,   // pad_number, sample_level, time_us
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dpt_pkg::OUT_W-1:0]        m_tdata,   // event_pad, note_number, note_velocity, channel_out
	output logic [0:0]                       m_tuser    // event_kind
);

	localparam int PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
	localparam int PN    = dpt_pkg::PAD_NUM_W;
	localparam int TW    = dpt_pkg::TIME_W;

	dpt_pkg::cfg_t   cfg_q;
	dpt_pkg::event_t out_q;
	dpt_pkg::event_t ev;
	logic            out_valid_q;
	logic            ev_valid;
	logic            ev_ready;

	logic                         rd_en;
	logic [PAD_W-1:0]             rd_addr;
	logic [1:0]                   rd_phase;
	logic [dpt_pkg::HIT_W-1:0]    rd_hit;
	logic [SAMPLE_BITS-1:0]       rd_peak;
	logic [TW-1:0]                rd_start;
	logic                         wr_en;
	logic [PAD_W-1:0]             wr_addr;
	logic [1:0]                   wr_phase;
	logic [dpt_pkg::HIT_W-1:0]    wr_hit;
	logic [SAMPLE_BITS-1:0]       wr_peak;
	logic [TW-1:0]                wr_start;
	logic [TW-1:0]                alu_a;
	logic [TW-1:0]                alu_b;
	logic [TW-1:0]                alu_diff;
	logic                         alu_ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr    <= dpt_pkg::RST_THRESHOLD;
			cfg_q.full   <= dpt_pkg::RST_FULL;
			cfg_q.hyst   <= dpt_pkg::RST_HYST;
			cfg_q.need   <= dpt_pkg::RST_DEBOUNCE;
			cfg_q.window <= dpt_pkg::RST_WINDOW;
			cfg_q.chan   <= dpt_pkg::RST_CHANNEL;
		end else if (cfg_wen) begin
			case (cfg_index)
				dpt_pkg::REG_THRESHOLD: cfg_q.thr    <= cfg_data[dpt_pkg::LEVEL_W-1:0];
				dpt_pkg::REG_FULL:      cfg_q.full   <= cfg_data[dpt_pkg::LEVEL_W-1:0];
				dpt_pkg::REG_HYST:      cfg_q.hyst   <= cfg_data[dpt_pkg::LEVEL_W-1:0];
				dpt_pkg::REG_DEBOUNCE:  cfg_q.need   <= cfg_data[dpt_pkg::HIT_W-1:0];
				dpt_pkg::REG_WINDOW:    cfg_q.window <= cfg_data[dpt_pkg::WINDOW_W-1:0];
				dpt_pkg::REG_CHANNEL:   cfg_q.chan   <= cfg_data[dpt_pkg::CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dpt_alu #(
		.W(TW)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	dpt_pad_mem #(
		.PAD_COUNT   (PAD_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_phase (rd_phase),
		.rd_hit   (rd_hit),
		.rd_peak  (rd_peak),
		.rd_start (rd_start),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_phase (wr_phase),
		.wr_hit   (wr_hit),
		.wr_peak  (wr_peak),
		.wr_start (wr_start)
	);

	dpt_ctrl #(
		.PAD_COUNT        (PAD_COUNT),
		.SAMPLE_BITS      (SAMPLE_BITS),
		.CURVE_INDEX_BITS (CURVE_INDEX_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pad    (s_tdata[PN-1:0]),
		.in_sample (s_tdata[PN +: SAMPLE_BITS]),
		.in_time   (s_tdata[PN + SAMPLE_BITS +: TW]),
		.ev_valid  (ev_valid),
		.ev_ready  (ev_ready),
		.ev        (ev),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_phase  (rd_phase),
		.rd_hit    (rd_hit),
		.rd_peak   (rd_peak),
		.rd_start  (rd_start),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_phase  (wr_phase),
		.wr_hit    (wr_hit),
		.wr_peak   (wr_peak),
		.wr_start  (wr_start),
		.alu_a     (alu_a),
		.alu_b     (alu_b),
		.alu_diff  (alu_diff),
		.alu_ge    (alu_ge)
	);

	assign ev_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ev_valid && ev_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && ev_ready) begin
			out_q <= ev;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {2'b00, out_q.chan, out_q.vel, out_q.note, out_q.pad};

endmodule
